### rtl/core/bimap_frequency_table_core_assert.svh
// Assertion macros for the frequency table core.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef BIMAP_FREQUENCY_TABLE_CORE_ASSERT_SVH
`define BIMAP_FREQUENCY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BFQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfq assertion failed");

// Next-cycle implication, disabled during reset.
`define BFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfq assertion failed");

`endif

### rtl/core/bfq_pkg.sv
// Shared types and constants for the frequency table core.
// No dependencies.
package bfq_pkg;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int HITS_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int SCNT_W = 7;

  localparam int S_DATA_W = 128;
  localparam int M_DATA_W = 328;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;
  localparam logic [HITS_W-1:0] HITS_ONE = HITS_W'(1);

  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET_VALUE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET_KEY   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [HITS_W-1:0] hits;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  result_key;
    logic [VAL_W-1:0]  result_value;
    logic [HITS_W-1:0] result_frequency;
    logic [KEY_W-1:0]  top_key;
    logic [VAL_W-1:0]  top_value;
    logic [HITS_W-1:0] top_frequency;
    logic [SCNT_W-1:0] stored_count;
  } result_t;

endpackage

### rtl/core/bimap_frequency_table_core.sv
// Top level of the frequency table core: ring of entry cells plus sequencer.
// Depends on bfq_pkg, bfq_cell and bfq_scan.
//
// Each transaction is accepted in ST_IDLE; in ST_SCAN the ring of cells rotates
// one full turn past the single key/value comparator at its head; in ST_DONE
// the result moves into the output register once that register is free. The
// entries return to their home cells at the end of every turn.
// A new transaction is accepted while the previous result still waits in the
// output register. Keys are appended in arrival order; op 0 counts a key,
// op 1 looks up by key, op 2 returns the most recently appended key holding
// the given value. Hit counts saturate at all ones.
module bimap_frequency_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bfq_pkg::S_DATA_W-1:0]    s_tdata,  // key, value
  input  logic [bfq_pkg::OP_W-1:0]        s_tuser,  // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bfq_pkg::M_DATA_W-1:0]    m_tdata,  // result_key, result_value,
                                                    // result_frequency, top_key,
                                                    // top_value, top_frequency,
                                                    // stored_count, zero pad
  output logic [bfq_pkg::STAT_W-1:0]      m_tuser   // status
);

  bfq_pkg::entry_t  ring [CAPACITY];
  bfq_pkg::entry_t  tail;
  bfq_pkg::result_t res;
  logic             shift;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    if (j == CAPACITY - 1) begin : g_last
      bfq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .entry_in  (tail),
        .entry_out (ring[j])
      );
    end else begin : g_mid
      bfq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .entry_in  (ring[j+1]),
        .entry_out (ring[j])
      );
    end
  end

  bfq_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata[63:0]),
    .in_value  (s_tdata[127:64]),
    .head      (ring[0]),
    .tail      (tail),
    .shift     (shift),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {1'b0,
                    res.stored_count,
                    res.top_frequency,
                    res.top_value,
                    res.top_key,
                    res.result_frequency,
                    res.result_value,
                    res.result_key};

endmodule

### rtl/core/bfq_cell.sv
// One slot of the rotating entry ring.
// Depends on bfq_pkg.
module bfq_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  bfq_pkg::entry_t entry_in,
  output bfq_pkg::entry_t entry_out
);

  logic                      valid;
  logic [bfq_pkg::KEY_W-1:0]  key;
  logic [bfq_pkg::VAL_W-1:0]  value;
  logic [bfq_pkg::HITS_W-1:0] hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= entry_in.key;
      value <= entry_in.value;
      hits  <= entry_in.hits;
    end
  end

  assign entry_out = '{valid: valid, key: key, value: value, hits: hits};

endmodule

### rtl/core/bfq_scan.sv
// Sequencer and single comparator: scans the ring head, updates entries on
// the way to the tail, tracks the leader and holds the output register.
// Depends on bfq_pkg and bimap_frequency_table_core_assert.svh.
`include "bimap_frequency_table_core_assert.svh"

module bfq_scan #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfq_pkg::OP_W-1:0]    in_op,
  input  logic [bfq_pkg::KEY_W-1:0]   in_key,
  input  logic [bfq_pkg::VAL_W-1:0]   in_value,
  input  bfq_pkg::entry_t             head,
  output bfq_pkg::entry_t             tail,
  output logic                        shift,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bfq_pkg::result_t            out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  bfq_pkg::state_t state, state_next;

  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            used;
  logic                        found;
  logic [bfq_pkg::OP_W-1:0]    op_reg;
  logic [bfq_pkg::KEY_W-1:0]   key_reg;
  logic [bfq_pkg::VAL_W-1:0]   value_reg;
  logic [bfq_pkg::KEY_W-1:0]   res_key;
  logic [bfq_pkg::VAL_W-1:0]   res_value;
  logic [bfq_pkg::HITS_W-1:0]  res_hits;
  logic [bfq_pkg::HITS_W-1:0]  best_hits;
  logic [bfq_pkg::KEY_W-1:0]   best_key;
  logic [bfq_pkg::VAL_W-1:0]   best_value;
  bfq_pkg::result_t            out_reg;

  logic                        accept;
  logic                        last_step;
  logic                        load_out;
  logic                        key_hit;
  logic                        val_hit;
  logic                        append;
  logic                        touch;
  logic [bfq_pkg::HITS_W-1:0]  hits_inc;
  logic [bfq_pkg::STAT_W-1:0]  status;
  logic [CNT_W+bfq_pkg::SCNT_W-1:0] used_ext;

  assign accept    = in_valid && in_ready;
  assign last_step = (state == bfq_pkg::ST_SCAN) && (cnt == CNT_W'(CAPACITY - 1));
  assign load_out  = (state == bfq_pkg::ST_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfq_pkg::ST_IDLE: if (in_valid) state_next = bfq_pkg::ST_SCAN;
      bfq_pkg::ST_SCAN: if (last_step) state_next = bfq_pkg::ST_DONE;
      bfq_pkg::ST_DONE: if (!out_valid || out_ready) state_next = bfq_pkg::ST_IDLE;
      default:          state_next = bfq_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    shift    = 1'b0;
    unique case (state)
      bfq_pkg::ST_IDLE: in_ready = 1'b1;
      bfq_pkg::ST_SCAN: shift    = 1'b1;
      bfq_pkg::ST_DONE: ;
      default:          ;
    endcase
  end

  // head compare and writeback
  always_comb begin
    key_hit  = head.valid && (head.key == key_reg);
    val_hit  = head.valid && (head.value == value_reg);
    append   = (op_reg == bfq_pkg::OP_INSERT) && !found && (cnt == used) &&
               (used < CNT_W'(CAPACITY));
    hits_inc = (head.hits == bfq_pkg::HITS_MAX) ? head.hits
                                                 : head.hits + bfq_pkg::HITS_ONE;
    tail     = head;
    touch    = 1'b0;
    case (op_reg)
      bfq_pkg::OP_INSERT: begin
        if (key_hit) begin
          tail.hits = hits_inc;
          touch     = 1'b1;
        end else if (append) begin
          tail  = '{valid: 1'b1, key: key_reg, value: value_reg, hits: bfq_pkg::HITS_ONE};
          touch = 1'b1;
        end
      end
      bfq_pkg::OP_GET_VALUE: touch = key_hit;
      bfq_pkg::OP_GET_KEY:   touch = val_hit;
      default:               touch = 1'b0;
    endcase
  end

  always_comb begin
    case (op_reg) inside
      bfq_pkg::OP_INSERT:    status = found ? bfq_pkg::STAT_OK : bfq_pkg::STAT_FULL;
      bfq_pkg::OP_GET_VALUE,
      bfq_pkg::OP_GET_KEY:   status = found ? bfq_pkg::STAT_OK : bfq_pkg::STAT_MISS;
      default:               status = bfq_pkg::STAT_MISS;
    endcase
  end

  assign used_ext = {{bfq_pkg::SCNT_W{1'b0}}, used};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfq_pkg::ST_IDLE;
      cnt        <= '0;
      used       <= '0;
      found      <= 1'b0;
      best_hits  <= '0;
      best_key   <= '0;
      best_value <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt   <= '0;
        found <= 1'b0;
      end else if (state == bfq_pkg::ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
        if (touch) begin
          found <= 1'b1;
          if ((op_reg == bfq_pkg::OP_INSERT) && (tail.hits > best_hits)) begin
            best_hits  <= tail.hits;
            best_key   <= tail.key;
            best_value <= tail.value;
          end
        end
        if (append) begin
          used <= used + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg    <= in_op;
      key_reg   <= in_key;
      value_reg <= in_value;
      res_key   <= in_key;
      res_value <= '0;
      res_hits  <= '0;
    end else if ((state == bfq_pkg::ST_SCAN) && touch) begin
      res_key   <= tail.key;
      res_value <= tail.value;
      res_hits  <= tail.hits;
    end
    if (load_out) begin
      out_reg <= '{status:           status,
                   result_key:       res_key,
                   result_value:     res_value,
                   result_frequency: res_hits,
                   top_key:          best_key,
                   top_value:        best_value,
                   top_frequency:    best_hits,
                   stored_count:     used_ext[bfq_pkg::SCNT_W-1:0]};
    end
  end

  assign out_res = out_reg;

  `BFQ_ASSERT_NEXT(a_accept_starts_scan, accept, (state == bfq_pkg::ST_SCAN) && (cnt == '0))
  `BFQ_ASSERT_NEXT(a_scan_ends_done, last_step, state == bfq_pkg::ST_DONE)
  `BFQ_ASSERT_NEXT(a_used_only_in_scan, state != bfq_pkg::ST_SCAN, $stable(used))
  `BFQ_ASSERT_NEXT(a_leader_monotonic, 1'b1, best_hits >= $past(best_hits))

endmodule

### tb/sv/freq_table_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the frequency table core: predicts every result from the inputs it
// accepts and checks each output transaction field by field. Depends on bfq_pkg.
package freq_table_sb_pkg;
  import bfq_pkg::*;

  class freq_table_scoreboard #(int DEPTH = 64);
    localparam int RV_LSB  = KEY_W;
    localparam int RF_LSB  = RV_LSB + VAL_W;
    localparam int TK_LSB  = RF_LSB + HITS_W;
    localparam int TV_LSB  = TK_LSB + KEY_W;
    localparam int TF_LSB  = TV_LSB + VAL_W;
    localparam int SC_LSB  = TF_LSB + HITS_W;
    localparam int PAD_LSB = SC_LSB + SCNT_W;

    bit [KEY_W-1:0]  slot_key [DEPTH];
    bit [VAL_W-1:0]  slot_value [DEPTH];
    bit [HITS_W-1:0] slot_hits [DEPTH];
    int unsigned     used_slots;
    bit [HITS_W-1:0] best_hits;
    bit [KEY_W-1:0]  best_key;
    int unsigned     best_slot;

    result_t expected_results[$];
    int errors;
    int n_checked;
    int n_ops[4];
    int n_full;
    int n_miss;

    function int find_key(bit [KEY_W-1:0] k);
      for (int i = 0; i < used_slots; i++) begin
        if (slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    // newest entry wins on duplicate values
    function int find_value(bit [VAL_W-1:0] v);
      for (int i = int'(used_slots) - 1; i >= 0; i--) begin
        if (slot_value[i] == v) return i;
      end
      return -1;
    endfunction

    // strict greater-than: a tie keeps the earlier leader
    function void promote(int s);
      if (slot_hits[s] > best_hits) begin
        best_hits = slot_hits[s];
        best_key  = slot_key[s];
        best_slot = s;
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      result_t want;
      int idx;
      want = '0;
      want.status = STAT_MISS;
      idx = -1;
      n_ops[op]++;
      case (op)
        OP_INSERT: begin
          idx = find_key(key);
          if (idx >= 0) begin
            if (slot_hits[idx] != HITS_MAX) slot_hits[idx]++;
            promote(idx);
            want.status = STAT_OK;
          end else if (used_slots < DEPTH) begin
            idx = used_slots;
            slot_key[idx]   = key;
            slot_value[idx] = value;
            slot_hits[idx]  = HITS_ONE;
            used_slots++;
            promote(idx);
            want.status = STAT_OK;
          end else begin
            want.status = STAT_FULL;
            n_full++;
          end
        end
        OP_GET_VALUE: begin
          idx = find_key(key);
          want.status = (idx >= 0) ? STAT_OK : STAT_MISS;
        end
        OP_GET_KEY: begin
          idx = find_value(value);
          want.status = (idx >= 0) ? STAT_OK : STAT_MISS;
        end
        default: ;
      endcase
      if (want.status == STAT_MISS) n_miss++;
      want.result_key = key;
      if (want.status == STAT_OK) begin
        want.result_key       = slot_key[idx];
        want.result_value     = slot_value[idx];
        want.result_frequency = slot_hits[idx];
      end
      if (best_hits != 0) begin
        want.top_key   = best_key;
        want.top_value = slot_value[best_slot];
      end
      want.top_frequency = best_hits;
      want.stored_count  = used_slots[SCNT_W-1:0];
      expected_results.push_back(want);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t tb: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_response(logic [STAT_W-1:0] status, logic [M_DATA_W-1:0] data);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t tb: unexpected result, expected none, actual status %h data %h",
                 $time, status, data);
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      check_field("status", want.status, status);
      check_field("result_key", want.result_key, data[0 +: KEY_W]);
      check_field("result_value", want.result_value, data[RV_LSB +: VAL_W]);
      check_field("result_frequency", want.result_frequency, data[RF_LSB +: HITS_W]);
      check_field("top_key", want.top_key, data[TK_LSB +: KEY_W]);
      check_field("top_value", want.top_value, data[TV_LSB +: VAL_W]);
      check_field("top_frequency", want.top_frequency, data[TF_LSB +: HITS_W]);
      check_field("stored_count", want.stored_count, data[SC_LSB +: SCNT_W]);
      check_field("pad", '0, data[M_DATA_W-1:PAD_LSB]);
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the frequency table core testbench: clock, reset, stream drivers and sink.
// Depends on bfq_pkg, freq_table_sb_pkg and bimap_frequency_table_core.
module tb_top;
  import bfq_pkg::*;
  import freq_table_sb_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 200;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] ALL_ONES = '1;
  localparam logic [KEY_W-1:0] ALT_A = 64'h5555_5555_5555_5555;
  localparam logic [KEY_W-1:0] ALT_B = 64'hAAAA_AAAA_AAAA_AAAA;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  freq_table_scoreboard #(CAPACITY) sb;
  bit [KEY_W-1:0] key_pool [72];
  bit [VAL_W-1:0] value_pool [8];
  int  burst_left;
  int  accepted_items;
  bit  hold_request;
  bit  hold_done;
  int  rx_cycle;

  bimap_frequency_table_core #(.CAPACITY(CAPACITY)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offer one transaction, wait for acceptance, then idle between bursts.
  task automatic issue(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= {value, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, key, value);
    accepted_items++;
    if (accepted_items == HOLD_AT) hold_request = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 80)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 2) == 0) return key_pool[$urandom_range(0, 7)];
      return key_pool[$urandom_range(0, 71)];
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  // Sink: checks results, stalls on its own pattern, one long hold-off.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_response(m_tuser, m_tdata);
      rx_cycle++;
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      case ((rx_cycle / 300) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (rx_cycle % 11) >= 4;
      endcase
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    int r;
    sb = new();
    burst_left = 3;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    foreach (value_pool[i]) value_pool[i] = {$urandom, $urandom};
    value_pool[0] = '0;
    value_pool[1] = ALL_ONES;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lookups and unused op on an empty table
    issue(OP_GET_VALUE, '0, '0);
    issue(OP_GET_KEY, ALL_ONES, '0);
    issue(OP_UNUSED, ALL_ONES, ALL_ONES);
    // leader changes, ties keep the earlier leader, repeat insert ignores value
    issue(OP_INSERT, '0, '0);
    issue(OP_INSERT, ALL_ONES, ALL_ONES);
    issue(OP_INSERT, '0, ALL_ONES);
    issue(OP_INSERT, ALL_ONES, 64'd5);
    issue(OP_INSERT, ALL_ONES, '0);
    // duplicate value: newest key returned
    issue(OP_INSERT, ALT_A, ALL_ONES);
    issue(OP_GET_KEY, ALT_B, ALL_ONES);
    issue(OP_GET_KEY, ALT_A, '0);
    issue(OP_GET_VALUE, ALL_ONES, ALT_A);
    issue(OP_GET_VALUE, ALT_B, ALT_B);
    issue(OP_GET_KEY, ALT_B, 64'h1234);
    issue(OP_UNUSED, ALT_A, ALT_B);
    issue(OP_INSERT, ALT_B, ALT_B);
    issue(OP_GET_KEY, '0, ALT_B);

    // random mix over a key pool larger than the table, so it fills up
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) op = OP_INSERT;
      else if (r < 75) op = OP_GET_VALUE;
      else if (r < 95) op = OP_GET_KEY;
      else op = OP_UNUSED;
      issue(op, pick_key(), pick_value());
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    $display("tb: %0d transactions checked: %0d inserts, %0d key lookups, %0d value lookups, %0d unused op",
             sb.n_checked, sb.n_ops[OP_INSERT], sb.n_ops[OP_GET_VALUE],
             sb.n_ops[OP_GET_KEY], sb.n_ops[OP_UNUSED]);
    $display("tb: %0d new keys refused by the full table, %0d misses, %0d keys held, leader hits %0d",
             sb.n_full, sb.n_miss, sb.used_slots, sb.best_hits);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
